### hdl/pfa_pkg.sv
package pfa_pkg;

  // default sizing of the partition table
  localparam int NUM_BLOCKS_DEF = 64;
  localparam int SIZE_BITS_DEF  = 16;

  // fixed port widths
  localparam int OPCODE_W    = 2;
  localparam int BLOCK_IDX_W = 6;
  localparam int SIZE_PORT_W = 16;
  localparam int MODE_W      = 2;
  localparam int COUNT_W     = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int TOTAL_W     = 22;

  // saturation point of both totals
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_REPORT  = 2'd2,
    OP_RESTART = 2'd3
  } op_t;

  // placement policies
  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_NEXT  = 2'd1,
    FIT_BEST  = 2'd2,
    FIT_WORST = 2'd3
  } fit_mode_t;

  // configuration register indexes
  typedef enum logic {
    REG_FIT_MODE    = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } cfg_reg_t;

  // commands common to every cell of the ring
  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  // commands to the scan unit
  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  // status from the scan unit
  typedef struct packed {
    logic last;
    logic found;
  } scan_stat_t;

endpackage

### hdl/partition_fit_allocator_top.sv
// a request is taken only while idle; the partition ring then rotates once past
// the head cell, where each partition is judged, and a finish step forms the output word
// no new request is taken until the word of the last one has been formed, as that
// waits for the full rotation of the partition ring past the head cell
// reset clears control, config, next pointer and internal sum; the partition
// table itself has no reset and is defined once loaded
module partition_fit_allocator_top import pfa_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [OPCODE_W-1:0]    opcode,
  input  logic [BLOCK_IDX_W-1:0] block_index,
  input  logic [SIZE_PORT_W-1:0] size_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   found,
  output logic [BLOCK_IDX_W-1:0] chosen_block,
  output logic [SIZE_PORT_W-1:0] leftover,
  output logic [TOTAL_W-1:0]     internal_total,
  output logic [TOTAL_W-1:0]     external_total,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
  localparam int BC_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SUM_A  = SIZE_BITS + IDX_W + 1;
  localparam int SUM_W  = (SUM_A > TOTAL_W + 1) ? SUM_A : TOTAL_W + 1;
  localparam int ACC_W  = ((SIZE_BITS > TOTAL_W) ? SIZE_BITS : TOTAL_W) + 1;
  localparam int WIDE_W = IDX_W + BLOCK_IDX_W;
  localparam int SZX_W  = SIZE_BITS + SIZE_PORT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  op_t                  op_q;
  logic [SIZE_BITS-1:0] req_q;
  fit_mode_t            fit_mode;
  logic [COUNT_W-1:0]   block_count;
  logic [IDX_W-1:0]     next_ptr;
  logic [TOTAL_W-1:0]   internal_sum;
  logic [TOTAL_W-1:0]   internal_sum_next;

  logic                 accept;
  op_t                  op_in;
  logic [SZX_W-1:0]     size_wide;
  logic [SIZE_BITS-1:0] size_in;
  logic                 load_en;
  cell_ctl_t            cell_ctl;
  scan_ctl_t            scan_ctl;
  scan_stat_t           stat;
  logic [IDX_W-1:0]     sel_idx;
  logic [SIZE_BITS-1:0] sel_rem;
  logic [SUM_W-1:0]     sum;
  logic [BC_W-1:0]      bc_wide;
  logic [BC_W-1:0]      count_eff;
  logic [IDX_W-1:0]     start;
  logic                 finish;
  logic                 alloc_ok;
  logic                 hit;
  logic [SIZE_BITS-1:0] left;
  logic [SZX_W-1:0]     left_wide;
  logic [ACC_W-1:0]     acc;
  logic [SUM_W-1:0]     ext_wide;
  logic [TOTAL_W-1:0]   ext_sat;
  logic [WIDE_W-1:0]    chosen_wide;

  logic [SIZE_BITS-1:0] c_orig  [NUM_BLOCKS];
  logic [SIZE_BITS-1:0] c_rem   [NUM_BLOCKS];
  logic                 c_given [NUM_BLOCKS];

  // input handshake and decode
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign op_in     = op_t'(opcode);
  assign size_wide = SZX_W'(size_value);
  assign size_in   = size_wide[SIZE_BITS-1:0];
  assign load_en   = accept && (op_in == OP_LOAD);

  // ring commands
  assign cell_ctl.shift   = (state == ST_SCAN);
  assign cell_ctl.restart = accept && (op_in == OP_RESTART);
  assign scan_ctl.clear   = accept;
  assign scan_ctl.step    = (state == ST_SCAN);

  // partitions in use and the next fit starting point
  assign bc_wide   = BC_W'(block_count);
  assign count_eff = (bc_wide > BC_W'(NUM_BLOCKS)) ? BC_W'(NUM_BLOCKS) : bc_wide;
  assign start     = (BC_W'(next_ptr) < count_eff) ? next_ptr : '0;

  // ring of partition cells, each passing its entry toward the head cell
  for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_ring
    localparam int NB = (g == NUM_BLOCKS - 1) ? 0 : g + 1;
    logic load_hit;
    logic clear_hit;

    assign load_hit  = load_en && ({{IDX_W{1'b0}}, block_index} == WIDE_W'(g));
    assign clear_hit = hit && (sel_idx == IDX_W'(g));

    pfa_cell #(
      .SIZE_BITS (SIZE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .load_en   (load_hit),
      .load_size (size_in),
      .clear_en  (clear_hit),
      .nb_orig   (c_orig[NB]),
      .nb_rem    (c_rem[NB]),
      .nb_given  (c_given[NB]),
      .orig      (c_orig[g]),
      .rem       (c_rem[g]),
      .given     (c_given[g])
    );
  end

  // policy selection and sum at the head cell
  pfa_scan #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .mode       (fit_mode),
    .req        (req_q),
    .count      (count_eff),
    .start      (start),
    .head_rem   (c_rem[0]),
    .head_given (c_given[0]),
    .stat       (stat),
    .sel_idx    (sel_idx),
    .sel_rem    (sel_rem),
    .sum        (sum)
  );

  // finish: place the request and form the totals
  always_comb begin
    finish    = (state == ST_DONE) && (!out_valid || out_ready);
    alloc_ok  = (op_q == OP_ALLOC) && stat.found;
    hit       = finish && alloc_ok;
    left      = sel_rem - req_q;
    left_wide = SZX_W'(left);
    acc       = ACC_W'(internal_sum) + ACC_W'(left);
    if (hit) begin
      internal_sum_next = (acc > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : acc[TOTAL_W-1:0];
    end else begin
      internal_sum_next = internal_sum;
    end
    ext_wide    = sum - (alloc_ok ? SUM_W'(sel_rem) : '0);
    ext_sat     = (ext_wide > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : ext_wide[TOTAL_W-1:0];
    chosen_wide = WIDE_W'(sel_idx);
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (stat.last) state_next = ST_DONE;
      ST_DONE: if (finish) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control state, configuration and running totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fit_mode     <= FIT_FIRST;
      block_count  <= '0;
      next_ptr     <= '0;
      internal_sum <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FIT_MODE:    fit_mode <= fit_mode_t'(cfg_data[MODE_W-1:0]);
          REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
          default:         block_count <= block_count;
        endcase
      end
      if (cell_ctl.restart) begin
        next_ptr     <= '0;
        internal_sum <= '0;
      end else begin
        internal_sum <= internal_sum_next;
        if (hit && (fit_mode == FIT_NEXT)) next_ptr <= sel_idx;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // captured request and output word
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op_in;
      req_q <= size_in;
    end
    if (finish) begin
      found          <= alloc_ok;
      chosen_block   <= alloc_ok ? chosen_wide[BLOCK_IDX_W-1:0] : '0;
      leftover       <= alloc_ok ? left_wide[SIZE_PORT_W-1:0] : '0;
      internal_total <= internal_sum_next;
      external_total <= ext_sat;
    end
  end

  // checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken again right after accept");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> (chosen_block == '0) && (leftover == '0))
    else $error("miss word carries a partition or leftover");

  a_next_ptr_moves: assert property (@(posedge clk) disable iff (rst)
    hit && (fit_mode == FIT_NEXT) |=> next_ptr == $past(sel_idx))
    else $error("next pointer not moved to the placed partition");

  a_word_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("output word raised outside the finish cycle");

endmodule

### hdl/pfa_cell.sv
module pfa_cell import pfa_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic                 load_en,
  input  logic [SIZE_BITS-1:0] load_size,
  input  logic                 clear_en,
  input  logic [SIZE_BITS-1:0] nb_orig,
  input  logic [SIZE_BITS-1:0] nb_rem,
  input  logic                 nb_given,
  output logic [SIZE_BITS-1:0] orig,
  output logic [SIZE_BITS-1:0] rem,
  output logic                 given
);

  // one partition: rotate from the neighbor, load, restore or give out
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      orig  <= nb_orig;
      rem   <= nb_rem;
      given <= nb_given;
    end else if (load_en) begin
      orig  <= load_size;
      rem   <= load_size;
      given <= 1'b0;
    end else if (ctl.restart) begin
      rem   <= orig;
      given <= 1'b0;
    end else if (clear_en) begin
      rem   <= '0;
      given <= 1'b1;
    end
  end

endmodule

### hdl/pfa_scan.sv
module pfa_scan import pfa_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int SIZE_BITS  = SIZE_BITS_DEF,
  localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
  localparam int CNT_W  = $clog2(NUM_BLOCKS + 1),
  localparam int BC_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W,
  localparam int SUM_A  = SIZE_BITS + IDX_W + 1,
  localparam int SUM_W  = (SUM_A > TOTAL_W + 1) ? SUM_A : TOTAL_W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scan_ctl_t            ctl,
  input  fit_mode_t            mode,
  input  logic [SIZE_BITS-1:0] req,
  input  logic [BC_W-1:0]      count,
  input  logic [IDX_W-1:0]     start,
  input  logic [SIZE_BITS-1:0] head_rem,
  input  logic                 head_given,
  output scan_stat_t           stat,
  output logic [IDX_W-1:0]     sel_idx,
  output logic [SIZE_BITS-1:0] sel_rem,
  output logic [SUM_W-1:0]     sum
);

  logic [IDX_W-1:0]     k;
  logic                 hi_v;
  logic [IDX_W-1:0]     hi_idx;
  logic [SIZE_BITS-1:0] hi_rem;
  logic                 lo_v;
  logic [IDX_W-1:0]     lo_idx;
  logic [SIZE_BITS-1:0] lo_rem;
  logic                 active;
  logic                 fit;
  logic                 take_hi;
  logic                 take_lo;

  // judge the partition now sitting in the head cell
  always_comb begin
    active  = BC_W'(k) < count;
    fit     = active && !head_given && (req <= head_rem);
    take_lo = (mode == FIT_NEXT) && fit && !lo_v;
    case (mode)
      FIT_FIRST: take_hi = fit && !hi_v;
      FIT_NEXT:  take_hi = fit && !hi_v && (k >= start);
      FIT_BEST:  take_hi = fit && (!hi_v || (head_rem < hi_rem));
      FIT_WORST: take_hi = fit && (!hi_v || (head_rem >= hi_rem));
      default:   take_hi = 1'b0;
    endcase
  end

  // candidate control state
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      hi_v <= 1'b0;
      lo_v <= 1'b0;
    end else if (ctl.clear) begin
      k    <= '0;
      hi_v <= 1'b0;
      lo_v <= 1'b0;
    end else if (ctl.step) begin
      k <= k + 1'b1;
      if (take_hi) hi_v <= 1'b1;
      if (take_lo) lo_v <= 1'b1;
    end
  end

  // candidate payload and running sum of remaining sizes
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum <= '0;
    end else if (ctl.step) begin
      sum <= sum + (active ? SUM_W'(head_rem) : '0);
      if (take_hi) begin
        hi_idx <= k;
        hi_rem <= head_rem;
      end
      if (take_lo) begin
        lo_idx <= k;
        lo_rem <= head_rem;
      end
    end
  end

  // next fit falls back to the wrapped candidate
  assign stat.last  = (k == IDX_W'(NUM_BLOCKS - 1));
  assign stat.found = hi_v || lo_v;
  assign sel_idx    = hi_v ? hi_idx : lo_idx;
  assign sel_rem    = hi_v ? hi_rem : lo_rem;

endmodule
